FILE: rtl/core/srt_pkg.sv
// Package for the sequence range tracker: shared codes and the cell command struct.
// No dependencies; used by the range cell and the top level.
package srt_pkg;

	// Result status codes.
	localparam logic [1:0] ST_ADDED   = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_CHECK   = 2'd3;

	// Function codes of an input word.
	localparam logic FN_ADD   = 1'b0;
	localparam logic FN_CHECK = 1'b1;

	// Update command broadcast to every cell; pos is compared by each cell with its index.
	typedef struct packed {
		logic        upd;       // perform an update this cycle
		logic        ext_low;   // extend the range just below: end of cell p-1 becomes seq
		logic        ext_high;  // extend the range just above: start of cell p becomes seq
		logic        merge;     // close the gap between cells p-1 and p
		logic        insert;    // open a new range at cell p
		logic [31:0] seq;
	} cell_cmd_t;

endpackage

FILE: rtl/core/srt_cell.sv
// One cell of the range chain: holds one range and reports compare flags.
// Depends on srt_pkg; takes both neighbours' ranges for shifting.
module srt_cell #(
	parameter int IdxW = 4
) (
	input  logic                   clk,
	input  logic [IdxW-1:0]        idx,
	input  logic [IdxW:0]          pos,
	input  srt_pkg::cell_cmd_t     cmd,
	input  logic [31:0]            seq,
	input  logic [31:0]            prev_start,
	input  logic [31:0]            prev_end,
	input  logic [31:0]            next_start,
	input  logic [31:0]            next_end,
	output logic [31:0]            start_val,
	output logic [31:0]            end_val,
	output logic                   holds,
	output logic                   below
);
	import srt_pkg::*;

	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [IdxW:0] me;

	assign me        = {1'b0, idx};
	assign start_val = start_q;
	assign end_val   = end_q;

	// Compare flags for the search cycle.
	assign holds = (start_q <= seq) && (seq <= end_q);
	assign below = (end_q < seq);

	// Update: extend, shift down on merge, shift up on insert.
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			if (cmd.merge) begin
				if (me + 1'b1 == pos) begin
					end_q <= next_end;
				end else if (me >= pos) begin
					start_q <= next_start;
					end_q   <= next_end;
				end
			end else if (cmd.ext_low) begin
				if (me + 1'b1 == pos) end_q <= cmd.seq;
			end else if (cmd.ext_high) begin
				if (me == pos) start_q <= cmd.seq;
			end else if (cmd.insert) begin
				if (me == pos) begin
					start_q <= cmd.seq;
					end_q   <= cmd.seq;
				end else if (me > pos) begin
					start_q <= prev_start;
					end_q   <= prev_end;
				end
			end
		end
	end

endmodule

FILE: rtl/core/sequence_range_tracker.sv
// Top level of the sequence range tracker: handshake, search and update control.
// Depends on srt_pkg and srt_cell.
//
// Usage: a word on the s_axis channel adds a sequence number or checks it;
// tuser selects the function and tlast marks the number as the final one.
// Each word gives one result word on m_axis with the status, the prior
// presence flag, the complete flag and the range count.
// Each cell of the chain holds one range. In the cycle after acceptance
// every cell compares the number with its range at once and the count of
// cells below it gives the insertion place; at the next edge the cells
// extend, merge (shift down from the upper neighbour) or insert (shift up
// from the lower neighbour) and the result word is registered. A new word
// is taken in the cycle the previous result word leaves, so no word is
// accepted while the previous one is in its compare then update step. The
// result register holds while m_axis_tready is low, and no new word is
// accepted until the result word has been taken.
// Reset empties the set and makes the expected final number all ones.
module sequence_range_tracker #(
	parameter int MAX_RANGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] seq_no
	input  logic        s_axis_tuser,  // [0] func
	input  logic        s_axis_tlast,  // is_last
	input  logic        m_axis_tready,
	output logic        m_axis_tvalid,
	output logic [15:0] m_axis_tdata   // [1:0] status, [2] present, [3] complete, [8:4] count
);
	import srt_pkg::*;

	localparam int IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CntW = $clog2(MAX_RANGES + 1);

	logic              busy_q;
	logic              func_q;
	logic [31:0]       seq_q;
	logic              last_q;
	logic [CntW-1:0]   used_q;
	logic [31:0]       final_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              present_q;
	logic              complete_q;
	logic [CntW-1:0]   count_q;

	logic [31:0] st [MAX_RANGES];
	logic [31:0] en [MAX_RANGES];
	logic [MAX_RANGES-1:0] hv, bv;
	logic [IdxW:0] pos;
	cell_cmd_t cmd;
	logic accept;

	assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Cell chain.
	for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
		logic [31:0] ps, pe, ns, ne;
		if (g == 0) begin : g_lo
			assign ps = '0;
			assign pe = '0;
		end else begin : g_mid
			assign ps = st[g-1];
			assign pe = en[g-1];
		end
		if (g == MAX_RANGES - 1) begin : g_hi
			assign ns = '0;
			assign ne = '0;
		end else begin : g_mid2
			assign ns = st[g+1];
			assign ne = en[g+1];
		end
		srt_cell #(.IdxW(IdxW)) u_cell (
			.clk, .idx(IdxW'(g)), .pos, .cmd, .seq(seq_q),
			.prev_start(ps), .prev_end(pe), .next_start(ns), .next_end(ne),
			.start_val(st[g]), .end_val(en[g]), .holds(hv[g]), .below(bv[g])
		);
	end

	// Validity masks and insertion place: count of used cells lying below the number.
	logic [MAX_RANGES-1:0] used_mask;
	always_comb begin
		for (int i = 0; i < MAX_RANGES; i++) used_mask[i] = (CntW'(i) < used_q);
	end
	assign pos = (IdxW+1)'($countones(bv & used_mask));

	logic was, jl, jh, full;
	logic [31:0] lo_end, hi_start;
	assign was = |(hv & used_mask);
	assign lo_end   = (pos != 0) ? en[IdxW'(pos - 1'b1)] : '0;
	assign hi_start = (pos < (IdxW+1)'(MAX_RANGES)) ? st[IdxW'(pos)] : '0;
	assign jl = (pos != 0) && (lo_end != 32'hFFFF_FFFF) && (lo_end + 32'd1 == seq_q);
	assign jh = ({1'b0, pos} < (IdxW+2)'(used_q)) && (hi_start != 32'd0)
		&& (hi_start - 32'd1 == seq_q);
	assign full = (used_q >= CntW'(MAX_RANGES));

	// Command for the update edge.
	always_comb begin
		cmd = '0;
		cmd.seq = seq_q;
		if (busy_q && func_q == FN_ADD && !was) begin
			cmd.upd      = 1'b1;
			cmd.merge    = jl && jh;
			cmd.ext_low  = jl && !jh;
			cmd.ext_high = jh && !jl;
			cmd.insert   = !jl && !jh && !full;
		end
	end

	// Next range count and final number, for the complete flag.
	logic [CntW-1:0] used_nx;
	logic [31:0] final_nx, s0_nx, e0_nx;
	always_comb begin
		used_nx = used_q;
		if (cmd.merge) used_nx = used_q - 1'b1;
		else if (cmd.insert) used_nx = used_q + 1'b1;
		final_nx = (busy_q && func_q == FN_ADD && last_q) ? seq_q : final_q;
		s0_nx = st[0];
		e0_nx = en[0];
		if (cmd.insert && pos == 0) begin
			s0_nx = seq_q; e0_nx = seq_q;
		end else if (cmd.ext_high && pos == 0) begin
			s0_nx = seq_q;
		end else if (cmd.ext_low && pos == 1) begin
			e0_nx = seq_q;
		end else if (cmd.merge && pos == 1) begin
			e0_nx = (MAX_RANGES > 1) ? en[IdxW'(1 % MAX_RANGES)] : en[0];
		end
	end

	// Control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			used_q      <= '0;
			final_q     <= 32'hFFFF_FFFF;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (accept) busy_q <= 1'b1;
			if (busy_q) begin
				busy_q      <= 1'b0;
				used_q      <= used_nx;
				final_q     <= final_nx;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_axis_tuser;
			seq_q  <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
		if (busy_q) begin
			present_q  <= was;
			count_q    <= used_nx;
			complete_q <= (used_nx == CntW'(1)) && (s0_nx == 32'd0) && (e0_nx == final_nx);
			if (func_q == FN_CHECK) status_q <= ST_CHECK;
			else if (was) status_q <= ST_PRESENT;
			else if (!jl && !jh && full) status_q <= ST_FULL;
			else status_q <= ST_ADDED;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, 5'(count_q), complete_q, present_q, status_q};

endmodule

FILE: tb/sv/tb_sequence_range_tracker.sv
// Self-checking testbench for the sequence range tracker: random and directed words
// on s_axis, results on m_axis compared with a behavioural range-set predictor.
// Depends on srt_pkg and the sequence_range_tracker RTL.
module tb_sequence_range_tracker;
	import srt_pkg::*;

	localparam int NRANGE = 16;

	typedef struct packed {
		logic        func;
		logic [31:0] seq_no;
		logic        is_last;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       present;
		logic       complete;
		logic [4:0] range_count;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tready;
	logic        m_axis_tvalid;
	logic [15:0] m_axis_tdata;

	sequence_range_tracker #(.MAX_RANGES(NRANGE)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state: the sorted range set.
	logic [31:0] lo_q [NRANGE];
	logic [31:0] hi_q [NRANGE];
	int          used_q;
	logic [31:0] final_q;

	req_t pending_words[$];
	res_t expected_results[$];
	int   mismatches;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_cycles;
	bit   hold_req;
	bit   hold_done;

	function automatic bit range_holds(logic [31:0] s);
		for (int i = 0; i < used_q; i++)
			if (lo_q[i] <= s && s <= hi_q[i]) return 1;
		return 0;
	endfunction

	function automatic logic [1:0] range_insert(logic [31:0] s);
		int p;
		bit jl, jh;
		p = 0;
		while (p < used_q && hi_q[p] < s) p++;
		jl = p > 0 && hi_q[p-1] != 32'hFFFF_FFFF && hi_q[p-1] + 32'd1 == s;
		jh = p < used_q && lo_q[p] != 32'd0 && lo_q[p] - 32'd1 == s;
		if (jl && jh) begin
			hi_q[p-1] = hi_q[p];
			for (int i = p; i + 1 < used_q; i++) begin
				lo_q[i] = lo_q[i+1];
				hi_q[i] = hi_q[i+1];
			end
			used_q--;
			return ST_ADDED;
		end
		if (jl) begin
			hi_q[p-1] = s;
			return ST_ADDED;
		end
		if (jh) begin
			lo_q[p] = s;
			return ST_ADDED;
		end
		if (used_q >= NRANGE) return ST_FULL;
		for (int i = used_q; i > p; i--) begin
			lo_q[i] = lo_q[i-1];
			hi_q[i] = hi_q[i-1];
		end
		lo_q[p] = s;
		hi_q[p] = s;
		used_q++;
		return ST_ADDED;
	endfunction

	function automatic res_t predict_result(req_t w);
		res_t r;
		r.present = range_holds(w.seq_no);
		if (w.func == FN_CHECK) begin
			r.status = ST_CHECK;
		end else begin
			if (w.is_last) final_q = w.seq_no;
			r.status = r.present ? ST_PRESENT : range_insert(w.seq_no);
		end
		r.complete = used_q == 1 && lo_q[0] == 32'd0 && hi_q[0] == final_q;
		r.range_count = used_q[4:0];
		return r;
	endfunction

	task automatic push_word(logic f, logic [31:0] s, logic l);
		req_t w;
		w.func = f;
		w.seq_no = s;
		w.is_last = l;
		pending_words.push_back(w);
	endtask

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Driver: offers the head of the pending queue, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_result(pending_words.pop_front()));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_words[0].seq_no;
					s_axis_tuser  <= pending_words[0].func;
					s_axis_tlast  <= pending_words[0].is_last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold, counted on its own.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cycles <= 200;
			hold_done   <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Monitor: compares each result word with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word %h", m_axis_tdata);
				end else begin
					res_t e;
					res_t a;
					e = expected_results.pop_front();
					a.status      = m_axis_tdata[1:0];
					a.present     = m_axis_tdata[2];
					a.complete    = m_axis_tdata[3];
					a.range_count = m_axis_tdata[8:4];
					if (a !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Mismatch: expected st=%0d pr=%0d cp=%0d n=%0d,",
							          " got st=%0d pr=%0d cp=%0d n=%0d"},
							         e.status, e.present, e.complete, e.range_count,
							         a.status, a.present, a.complete, a.range_count);
					end
				end
			end
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [31:0] b;
		int n;
		mismatches = 0;
		hold_req = 1'b0;
		used_q = 0;
		final_q = 32'hFFFF_FFFF;
		for (int i = 0; i < NRANGE; i++) begin
			lo_q[i] = '0;
			hi_q[i] = '0;
		end
		send_idle_pct = 23;
		recv_idle_pct = 61;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: an empty set check, ends of the space, merging and a full table.
		push_word(FN_CHECK, 32'd5, 1'b1);
		push_word(FN_ADD, 32'hFFFF_FFFF, 1'b0);
		push_word(FN_ADD, 32'd0, 1'b0);
		push_word(FN_ADD, 32'd2, 1'b1);
		push_word(FN_ADD, 32'd1, 1'b0);
		push_word(FN_ADD, 32'd1, 1'b0);
		push_word(FN_CHECK, 32'hFFFF_FFFF, 1'b0);
		push_word(FN_ADD, 32'hFFFF_FFFE, 1'b0);
		for (int i = 0; i < 16; i++) push_word(FN_ADD, 32'd100 + 32'(4 * i), 1'b0);
		push_word(FN_ADD, 32'd3, 1'b1);
		push_word(FN_ADD, 32'd50, 1'b1);
		push_word(FN_ADD, 32'd101, 1'b0);
		push_word(FN_ADD, 32'd102, 1'b0);
		while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);

		// Random: mostly fragment runs near a base at either end of the space, with noise across the space.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 61;
				recv_idle_pct = 23;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < 267; k++) begin
				n = $urandom_range(99);
				b = (k % 90 < 45) ? 32'd0 : 32'hFFFF_FFC0;
				if (n < 70)
					push_word(FN_ADD, b + 32'($urandom_range(40)), $urandom_range(15) == 0);
				else if (n < 85)
					push_word(FN_CHECK, b + 32'($urandom_range(40)), 1'($urandom_range(1)));
				else
					push_word(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
			end
			if (ph == 2) hold_req = 1'b1;
			while (pending_words.size() != 0 || expected_results.size() != 0)
				@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS sequence_range_tracker");
		end else begin
			$display("FAIL sequence_range_tracker");
		end
		$finish;
	end

	// Timeout.
	initial begin
		#2000000;
		$display("FAIL sequence_range_tracker");
		$finish;
	end
endmodule
